@@ rtl/core/msp_pkg.sv @@
// Shared types and constants of the multi-source parameter ramp.
package msp_pkg;

   localparam int MSP_SOURCES    = 8;
   localparam int MSP_FRAC_EXTRA = 16;
   localparam int MSP_STEPS_W    = 24;   // width of a glide step count

   localparam logic [19:0] MSP_FRAME_RESET  = 20'd10667;
   localparam logic [3:0]  MSP_ACTIVE_RESET = 4'd8;

   // gains in dB, Q10.8
   localparam logic signed [17:0] GAIN_MUTE_DB  = -18'sd51200;   // -200 dB
   localparam logic signed [17:0] GAIN_FLOOR_DB = -18'sd38400;   // -150 dB

   localparam logic [2:0] CSR_FRAME_ADDR  = 3'h0;
   localparam logic [2:0] CSR_ACTIVE_ADDR = 3'h4;

   typedef enum logic [1:0] {
      MSP_OP_SET  = 2'd0,
      MSP_OP_MUTE = 2'd1,
      MSP_OP_TICK = 2'd2
   } msp_op_type;

   typedef enum logic [2:0] {
      MSP_IDLE,
      MSP_N_WAIT,
      MSP_F_START,
      MSP_F_WAIT,
      MSP_SET_WR,
      MSP_TICK_RD,
      MSP_TICK_UPD
   } msp_state_type;

   typedef enum logic [1:0] {
      MSP_FLD_X = 2'd0,
      MSP_FLD_Y = 2'd1,
      MSP_FLD_Z = 2'd2,
      MSP_FLD_G = 2'd3
   } msp_field_type;

   typedef struct packed {
      logic busy;
      logic done;
   } msp_div_status_type;

endpackage

@@ rtl/core/msp_if.sv @@
// Request and response channel interfaces of the parameter ramp.
interface msp_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [2:0]          source_index;
   logic signed [15:0]  target_x;
   logic signed [15:0]  target_y;
   logic signed [15:0]  target_z;
   logic signed [17:0]  target_gain;
   logic [23:0]         ramp_time_us;

   modport source (output valid, op, source_index, target_x, target_y, target_z,
                   target_gain, ramp_time_us, input ready);
   modport sink   (input valid, op, source_index, target_x, target_y, target_z,
                   target_gain, ramp_time_us, output ready);
endinterface

interface msp_rsp_if;
   logic                valid;
   logic                ready;
   logic [2:0]          out_source;
   logic signed [15:0]  position_x;
   logic signed [15:0]  position_y;
   logic signed [15:0]  position_z;
   logic signed [17:0]  gain_level;
   logic                audible;
   logic                last;

   modport source (output valid, out_source, position_x, position_y, position_z,
                   gain_level, audible, last, input ready);
   modport sink   (input valid, out_source, position_x, position_y, position_z,
                   gain_level, audible, last, output ready);
endinterface

@@ rtl/core/msp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module msp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/msp_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module msp_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output logic [NUM_W-1:0]            quo,
   output msp_pkg::msp_div_status_type status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;   // dividend bits out, quotient bits in
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo         = num_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/core/msp_sat_add.sv @@
// Saturating add of a signed increment one bit wider than the accumulator.
module msp_sat_add #(
   parameter int W = 32
) (
   input  logic signed [W-1:0] acc,
   input  logic signed [W:0]   inc,
   output logic signed [W-1:0] sum
);

   logic [W+1:0] full;

   always_comb begin
      full = {{2{acc[W-1]}}, acc} + {inc[W], inc};
      if (full[W+1:W-1] == 3'b000 || full[W+1:W-1] == 3'b111) begin
         sum = full[W-1:0];
      end else if (full[W+1]) begin
         sum = {1'b1, {(W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(W-1){1'b1}}};
      end
   end

endmodule

@@ rtl/core/multi_source_parameter_ramp.sv @@
// Top level of the multi-source parameter ramp: sequencer, state stores, CSRs.
//
// Keeps x/y/z position (Q4.12 at the ports) and gain in dB (Q10.8) for up to
// SOURCES sources, held internally with FRAC_EXTRA more fraction bits. op 0
// sets one source: ramp time zero jumps it to the target, otherwise a glide of
// n = ceil(ramp/frame) blocks is planned with per-block steps (target-cur)/n,
// truncated toward zero. op 1 mutes every source (-200 dB). op 2 is a block
// tick: each active source with steps left advances (saturating), a source
// below -150 dB has its position zeroed, and one response transaction per
// active source goes out, the last flagged. A jump, mute, ignored set or
// unused op is handled entirely in the idle state. A timed set runs five
// divisions (the block count, then four steps) one after another through
// one radix-2 divider of DIV_W = max(24, 18+FRAC_EXTRA) bits that retires
// one quotient bit per cycle. A tick walks the active sources in order,
// each one a read and a write-back of the state RAMs, and stalls while the
// response register is still held. The request side is ready only between
// transactions. Per-source valid and mute flags in flops supply the reset
// values, so no clearing pass is needed after reset.
// CSRs: frame_time_us at 0x0 (0 acts as 1), active_sources at 0x4 (clamped to
// SOURCES).
module multi_source_parameter_ramp #(
   parameter int SOURCES    = msp_pkg::MSP_SOURCES,
   parameter int FRAC_EXTRA = msp_pkg::MSP_FRAC_EXTRA
) (
   input  logic        clock,
   input  logic        reset,
   msp_req_if.sink     req_bus,
   msp_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // internal formats
   localparam int P_W    = 16 + FRAC_EXTRA;          // position
   localparam int G_W    = 18 + FRAC_EXTRA;          // gain
   localparam int PS_W   = P_W + 1;                  // position step
   localparam int GS_W   = G_W + 1;                  // gain step
   localparam int SL_W   = msp_pkg::MSP_STEPS_W;
   localparam int IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int CNT_W  = $clog2(SOURCES + 1);
   localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;
   localparam int DIV_W  = (G_W > SL_W) ? G_W : SL_W;
   localparam int CUR_W  = 3 * P_W + G_W;
   localparam int STEP_W = 3 * PS_W + GS_W + SL_W;

   localparam logic signed [G_W-1:0] GAIN_MUTE  =
      G_W'(msp_pkg::GAIN_MUTE_DB) <<< FRAC_EXTRA;
   localparam logic signed [G_W-1:0] GAIN_FLOOR =
      G_W'(msp_pkg::GAIN_FLOOR_DB) <<< FRAC_EXTRA;

   // ---------------------------------------------------------------- CSRs
   logic [19:0] frame_ff, frame_in;
   logic [3:0]  active_ff, active_in;
   logic        csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      frame_in  = frame_ff;
      active_in = active_ff;
      if (csr_wr) begin
         case (csr_paddr)
            msp_pkg::CSR_FRAME_ADDR:  frame_in  = csr_pwdata[19:0];
            msp_pkg::CSR_ACTIVE_ADDR: active_in = csr_pwdata[3:0];
            default: ;
         endcase
      end
      case (csr_paddr)
         msp_pkg::CSR_FRAME_ADDR:  csr_prdata = 32'(frame_ff);
         msp_pkg::CSR_ACTIVE_ADDR: csr_prdata = 32'(active_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // effective frame time and active count
   logic [19:0]      frame_eff;
   logic [CMP_W-1:0] n_act_cmp;
   logic [CNT_W-1:0] n_active;

   always_comb begin
      frame_eff = (frame_ff == 20'd0) ? 20'd1 : frame_ff;
      n_act_cmp = (CMP_W'(active_ff) > CMP_W'(SOURCES)) ? CMP_W'(SOURCES)
                                                        : CMP_W'(active_ff);
      n_active  = CNT_W'(n_act_cmp);
   end

   // ------------------------------------------------------ state registers
   msp_pkg::msp_state_type state_ff, state_in;
   msp_pkg::msp_field_type fld_ff, fld_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SL_W-1:0]        n_ff, n_in;
   logic                   neg_ff, neg_in;
   logic signed [P_W-1:0]  tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;
   logic signed [G_W-1:0]  tg_ff, tg_in;
   logic signed [PS_W-1:0] stx_ff, stx_in, sty_ff, sty_in, stz_ff, stz_in;
   logic signed [GS_W-1:0] stg_ff, stg_in;
   logic [SOURCES-1:0]     cur_valid_ff, cur_valid_in;
   logic [SOURCES-1:0]     muted_ff, muted_in;
   logic [SOURCES-1:0]     step_valid_ff, step_valid_in;

   // ------------------------------------------------------------- stores
   logic              cur_we;
   logic [IDX_W-1:0]  cur_waddr;
   logic [CUR_W-1:0]  cur_wdata, cur_rd;
   logic              step_we;
   logic [STEP_W-1:0] step_wdata, step_rd;

   msp_ram #(.WIDTH(CUR_W), .DEPTH(SOURCES)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (idx_ff),
      .rd_data (cur_rd)
   );

   msp_ram #(.WIDTH(STEP_W), .DEPTH(SOURCES)) u_step_ram (
      .clock   (clock),
      .wr_en   (step_we),
      .wr_addr (idx_ff),
      .wr_data (step_wdata),
      .rd_addr (idx_ff),
      .rd_data (step_rd)
   );

   // ------------------------------------------------------------ divider
   logic                        div_start;
   logic [DIV_W-1:0]            div_num, div_quo;
   logic [SL_W-1:0]             div_den;
   msp_pkg::msp_div_status_type div_st;

   msp_div #(.NUM_W(DIV_W), .DEN_W(SL_W)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_quo),
      .status (div_st)
   );

   // ------------------------------------------- effective stored values
   // unwritten entries read as reset values, muted ones as -200 dB
   logic signed [P_W-1:0]  ex, ey, ez;
   logic signed [G_W-1:0]  eg;
   logic signed [PS_W-1:0] sx, sy, sz;
   logic signed [GS_W-1:0] sg;
   logic [SL_W-1:0]        esl;
   logic                   cv, sv;

   always_comb begin
      cv  = cur_valid_ff[idx_ff];
      sv  = step_valid_ff[idx_ff];
      ex  = cv ? $signed(cur_rd[G_W + 2*P_W +: P_W]) : '0;
      ey  = cv ? $signed(cur_rd[G_W + P_W +: P_W]) : '0;
      ez  = cv ? $signed(cur_rd[G_W +: P_W]) : '0;
      eg  = (cv && !muted_ff[idx_ff]) ? $signed(cur_rd[G_W-1:0]) : GAIN_MUTE;
      sx  = $signed(step_rd[SL_W + GS_W + 2*PS_W +: PS_W]);
      sy  = $signed(step_rd[SL_W + GS_W + PS_W +: PS_W]);
      sz  = $signed(step_rd[SL_W + GS_W +: PS_W]);
      sg  = $signed(step_rd[SL_W +: GS_W]);
      esl = sv ? step_rd[SL_W-1:0] : '0;
   end

   // --------------------------------------------------- tick datapath
   logic signed [P_W-1:0] nx, ny, nz, vx, vy, vz, px, py, pz;
   logic signed [G_W-1:0] ng, vg;
   logic                  stepping, aud, last_w;

   msp_sat_add #(.W(P_W)) u_add_x (.acc(ex), .inc(sx), .sum(nx));
   msp_sat_add #(.W(P_W)) u_add_y (.acc(ey), .inc(sy), .sum(ny));
   msp_sat_add #(.W(P_W)) u_add_z (.acc(ez), .inc(sz), .sum(nz));
   msp_sat_add #(.W(G_W)) u_add_g (.acc(eg), .inc(sg), .sum(ng));

   always_comb begin
      stepping = esl != '0;
      vx  = stepping ? nx : ex;
      vy  = stepping ? ny : ey;
      vz  = stepping ? nz : ez;
      vg  = stepping ? ng : eg;
      aud = !(vg < GAIN_FLOOR);
      px  = aud ? vx : '0;
      py  = aud ? vy : '0;
      pz  = aud ? vz : '0;
      last_w = (CNT_W'(idx_ff) + CNT_W'(1)) == n_active;
   end

   // ---------------------------------------------- set-target datapath
   logic signed [P_W-1:0] jx, jy, jz;
   logic signed [G_W-1:0] jg;
   logic signed [G_W:0]   d_sel, mag, q_ext, sval;
   logic                  k_bad;
   logic [IDX_W-1:0]      k_addr;

   always_comb begin
      jx = P_W'(req_bus.target_x) <<< FRAC_EXTRA;
      jy = P_W'(req_bus.target_y) <<< FRAC_EXTRA;
      jz = P_W'(req_bus.target_z) <<< FRAC_EXTRA;
      jg = G_W'(req_bus.target_gain) <<< FRAC_EXTRA;
      k_bad  = CMP_W'(req_bus.source_index) >= n_act_cmp;
      k_addr = IDX_W'(req_bus.source_index);

      case (fld_ff)
         msp_pkg::MSP_FLD_X: d_sel = (G_W+1)'(tx_ff) - (G_W+1)'(ex);
         msp_pkg::MSP_FLD_Y: d_sel = (G_W+1)'(ty_ff) - (G_W+1)'(ey);
         msp_pkg::MSP_FLD_Z: d_sel = (G_W+1)'(tz_ff) - (G_W+1)'(ez);
         default:            d_sel = (G_W+1)'(tg_ff) - (G_W+1)'(eg);
      endcase
      mag   = d_sel[G_W] ? -d_sel : d_sel;
      // quotient never exceeds the magnitude, so it fits the step width
      q_ext = $signed((G_W+1)'(div_quo));
      sval  = neg_ff ? -q_ext : q_ext;
   end

   // ----------------------------------------------------- response slot
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_src_ff, rsp_src_in;
   logic signed [15:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic signed [17:0]    rsp_g_ff, rsp_g_in;
   logic                  rsp_aud_ff, rsp_aud_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  tick_fire;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      fld_in        = fld_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      neg_in        = neg_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      tz_in         = tz_ff;
      tg_in         = tg_ff;
      stx_in        = stx_ff;
      sty_in        = sty_ff;
      stz_in        = stz_ff;
      stg_in        = stg_ff;
      cur_valid_in  = cur_valid_ff;
      muted_in      = muted_ff;
      step_valid_in = step_valid_ff;
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      cur_we        = 1'b0;
      cur_waddr     = idx_ff;
      cur_wdata     = {px, py, pz, vg};
      step_we       = 1'b0;
      step_wdata    = {sx, sy, sz, sg, esl - SL_W'(1)};
      tick_fire     = 1'b0;

      case (state_ff)
         msp_pkg::MSP_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               case (req_bus.op)
                  msp_pkg::MSP_OP_SET: begin
                     if (!k_bad) begin
                        if (req_bus.ramp_time_us == '0) begin
                           // jump: write target, cancel any glide
                           cur_we                = 1'b1;
                           cur_waddr             = k_addr;
                           cur_wdata             = {jx, jy, jz, jg};
                           cur_valid_in[k_addr]  = 1'b1;
                           muted_in[k_addr]      = 1'b0;
                           step_valid_in[k_addr] = 1'b0;
                        end else begin
                           // n - 1 = floor((ramp - 1) / frame)
                           idx_in    = k_addr;
                           tx_in     = jx;
                           ty_in     = jy;
                           tz_in     = jz;
                           tg_in     = jg;
                           div_start = 1'b1;
                           div_num   = DIV_W'(req_bus.ramp_time_us - SL_W'(1));
                           div_den   = SL_W'(frame_eff);
                           state_in  = msp_pkg::MSP_N_WAIT;
                        end
                     end
                  end
                  msp_pkg::MSP_OP_MUTE: muted_in = '1;
                  msp_pkg::MSP_OP_TICK: begin
                     if (n_active != '0) begin
                        idx_in   = '0;
                        state_in = msp_pkg::MSP_TICK_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         msp_pkg::MSP_N_WAIT: begin
            if (div_st.done) begin
               n_in     = div_quo[SL_W-1:0] + SL_W'(1);
               fld_in   = msp_pkg::MSP_FLD_X;
               state_in = msp_pkg::MSP_F_START;
            end
         end

         msp_pkg::MSP_F_START: begin
            div_start = 1'b1;
            div_num   = DIV_W'(mag[G_W-1:0]);
            div_den   = n_ff;
            neg_in    = d_sel[G_W];
            state_in  = msp_pkg::MSP_F_WAIT;
         end

         msp_pkg::MSP_F_WAIT: begin
            if (div_st.done) begin
               case (fld_ff)
                  msp_pkg::MSP_FLD_X: stx_in = sval[PS_W-1:0];
                  msp_pkg::MSP_FLD_Y: sty_in = sval[PS_W-1:0];
                  msp_pkg::MSP_FLD_Z: stz_in = sval[PS_W-1:0];
                  default:            stg_in = sval;
               endcase
               if (fld_ff == msp_pkg::MSP_FLD_G) begin
                  state_in = msp_pkg::MSP_SET_WR;
               end else begin
                  fld_in   = msp_pkg::msp_field_type'(fld_ff + 2'd1);
                  state_in = msp_pkg::MSP_F_START;
               end
            end
         end

         msp_pkg::MSP_SET_WR: begin
            step_we               = 1'b1;
            step_wdata            = {stx_ff, sty_ff, stz_ff, stg_ff, n_ff};
            step_valid_in[idx_ff] = 1'b1;
            state_in              = msp_pkg::MSP_IDLE;
         end

         msp_pkg::MSP_TICK_RD: state_in = msp_pkg::MSP_TICK_UPD;

         msp_pkg::MSP_TICK_UPD: begin
            if (out_free) begin
               tick_fire            = 1'b1;
               cur_we               = 1'b1;
               cur_valid_in[idx_ff] = 1'b1;
               muted_in[idx_ff]     = 1'b0;
               step_we              = stepping;
               if (last_w) begin
                  state_in = msp_pkg::MSP_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = msp_pkg::MSP_TICK_RD;
               end
            end
         end

         default: state_in = msp_pkg::MSP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = tick_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_src_in   = rsp_src_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_aud_in   = rsp_aud_ff;
      rsp_last_in  = last_w;
      if (tick_fire) begin
         rsp_src_in = 3'(idx_ff);
         rsp_x_in   = px[FRAC_EXTRA +: 16];   // floor shift of the extra bits
         rsp_y_in   = py[FRAC_EXTRA +: 16];
         rsp_z_in   = pz[FRAC_EXTRA +: 16];
         rsp_g_in   = vg[FRAC_EXTRA +: 18];
         rsp_aud_in = aud;
      end else begin
         rsp_last_in = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msp_pkg::MSP_IDLE;
         frame_ff      <= msp_pkg::MSP_FRAME_RESET;
         active_ff     <= msp_pkg::MSP_ACTIVE_RESET;
         cur_valid_ff  <= '0;
         muted_ff      <= '0;
         step_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_ff      <= frame_in;
         active_ff     <= active_in;
         cur_valid_ff  <= cur_valid_in;
         muted_ff      <= muted_in;
         step_valid_ff <= step_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      fld_ff      <= fld_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      tz_ff       <= tz_in;
      tg_ff       <= tg_in;
      stx_ff      <= stx_in;
      sty_ff      <= sty_in;
      stz_ff      <= stz_in;
      stg_ff      <= stg_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_aud_ff  <= rsp_aud_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_source = rsp_src_ff;
   assign rsp_bus.position_x = rsp_x_ff;
   assign rsp_bus.position_y = rsp_y_ff;
   assign rsp_bus.position_z = rsp_z_ff;
   assign rsp_bus.gain_level = rsp_g_ff;
   assign rsp_bus.audible    = rsp_aud_ff;
   assign rsp_bus.last       = rsp_last_ff;

   // ------------------------------------------------------- assertions
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == msp_pkg::MSP_N_WAIT ||
                       state_ff == msp_pkg::MSP_F_WAIT))
      else $error("divider finished outside a wait state");

   a_ready_div_free: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_st.busy)
      else $error("request accepted while divider busy");

   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && last_w) |=> state_ff == msp_pkg::MSP_IDLE)
      else $error("tick walk continued past last source");

   a_tick_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msp_pkg::MSP_TICK_RD || state_ff == msp_pkg::MSP_TICK_UPD)
      |-> (CNT_W'(idx_ff) < n_active))
      else $error("tick index beyond active count");

   a_set_wr_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == msp_pkg::MSP_SET_WR |-> $past(div_st.done))
      else $error("step write without a finished division");

endmodule

@@ test/multi_source_parameter_ramp_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the multi-source parameter ramp, with its own ramp predictor.
module multi_source_parameter_ramp_tb;
   import msp_pkg::*;

   // Pacing and limits. SETTLE_CYCLES covers the longest silent transaction,
   // a timed set.
   localparam int         IDLE_PCT      = 6;
   localparam int         SETTLE_CYCLES = 250;
   localparam int         LONG_HOLD     = 300;
   localparam int         STALL_LIMIT   = 5000;
   localparam int         PHASE_ITEMS   = 22;
   localparam int         PHASES        = 6;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // Internal fixed point: FRAC_EXTRA more fraction bits than the ports.
   localparam int     POS_W      = 16 + MSP_FRAC_EXTRA;
   localparam int     GAIN_W     = 18 + MSP_FRAC_EXTRA;
   localparam longint SCALE      = longint'(1) <<< MSP_FRAC_EXTRA;
   localparam longint GAIN_MUTE  = longint'(GAIN_MUTE_DB) * SCALE;
   localparam longint GAIN_FLOOR = longint'(GAIN_FLOOR_DB) * SCALE;
   localparam int     FRAME_DEF  = int'(MSP_FRAME_RESET);

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  src;
      logic [15:0] tx;
      logic [15:0] ty;
      logic [15:0] tz;
      logic [17:0] gain;
      logic [23:0] ramp;
   } ramp_cmd_t;

   typedef struct packed {
      logic [2:0]  src;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [17:0] gain;
      logic        audible;
      logic        last;
   } source_frame_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();

   multi_source_parameter_ramp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Ramp predictor state: registers plus per-source glide state.
   // Steps are kept as exact quotients; with a one-block glide the step can
   // span the whole position range and need one bit more than the position.
   // ---------------------------------------------------------------------
   logic [19:0]              frame_us;
   logic [3:0]               active_cfg;
   logic signed [POS_W-1:0]  pos_now   [MSP_SOURCES][3];
   longint                   pos_step  [MSP_SOURCES][3];
   logic signed [GAIN_W-1:0] gain_now  [MSP_SOURCES];
   longint                   gain_step [MSP_SOURCES];
   logic [MSP_STEPS_W-1:0]   glide_left [MSP_SOURCES];
   logic                     audible_now [MSP_SOURCES];

   source_frame_t pending_frames [$];
   int            errors;
   int            idle_cycles;
   bit            steady_flow;     // both sides stop idling while set
   bit            long_hold_req;   // asks the receiver for one long stall

   function automatic longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic int sources_in_use();
      return (active_cfg > MSP_SOURCES) ? MSP_SOURCES : int'(active_cfg);
   endfunction

   function automatic void reset_ramp_state();
      frame_us   = MSP_FRAME_RESET;
      active_cfg = MSP_ACTIVE_RESET;
      for (int i = 0; i < MSP_SOURCES; i++) begin
         for (int a = 0; a < 3; a++) begin
            pos_now[i][a]  = '0;
            pos_step[i][a] = 0;
         end
         gain_now[i]    = GAIN_W'(GAIN_MUTE);
         gain_step[i]   = 0;
         glide_left[i]  = '0;
         audible_now[i] = 1'b0;
      end
   endfunction

   // Applies one accepted transaction and queues the source frames it causes.
   function automatic void advance_ramps(ramp_cmd_t cmd);
      longint        tgt [3];
      longint        gain_tgt;
      longint        frame_eff;
      longint        blocks;
      int            k;
      int            n_src;
      source_frame_t fr;
      tgt[0]    = longint'($signed(cmd.tx)) * SCALE;
      tgt[1]    = longint'($signed(cmd.ty)) * SCALE;
      tgt[2]    = longint'($signed(cmd.tz)) * SCALE;
      gain_tgt  = longint'($signed(cmd.gain)) * SCALE;
      frame_eff = (frame_us == 0) ? 64'sd1 : longint'(frame_us);
      k         = int'(cmd.src);
      n_src     = sources_in_use();
      case (cmd.op)
         MSP_OP_SET: begin
            // sets aimed past the active count are dropped
            if (k < n_src) begin
               if (cmd.ramp == 0) begin
                  // jump: lands on the target and cancels any glide
                  for (int a = 0; a < 3; a++) pos_now[k][a] = POS_W'(tgt[a]);
                  gain_now[k]   = GAIN_W'(gain_tgt);
                  glide_left[k] = '0;
               end else begin
                  blocks = (longint'(cmd.ramp) + frame_eff - 1) / frame_eff;
                  for (int a = 0; a < 3; a++)
                     pos_step[k][a] = (tgt[a] - longint'(pos_now[k][a])) / blocks;
                  gain_step[k]  = (gain_tgt - longint'(gain_now[k])) / blocks;
                  glide_left[k] = MSP_STEPS_W'(blocks);
               end
            end
         end
         MSP_OP_MUTE: begin
            // only gains change; glides keep stepping from the muted level
            for (int i = 0; i < MSP_SOURCES; i++) gain_now[i] = GAIN_W'(GAIN_MUTE);
         end
         MSP_OP_TICK: begin
            for (int i = 0; i < n_src; i++) begin
               if (glide_left[i] != 0) begin
                  for (int a = 0; a < 3; a++)
                     pos_now[i][a] = POS_W'(saturate(longint'(pos_now[i][a]) + pos_step[i][a],
                                                     POS_W));
                  gain_now[i] = GAIN_W'(saturate(longint'(gain_now[i]) + gain_step[i], GAIN_W));
                  glide_left[i] = glide_left[i] - 1'b1;
               end
               if (longint'(gain_now[i]) < GAIN_FLOOR) begin
                  for (int a = 0; a < 3; a++) pos_now[i][a] = '0;
                  audible_now[i] = 1'b0;
               end else begin
                  audible_now[i] = 1'b1;
               end
               // port values: drop the extra fraction bits, rounding down
               fr.src     = 3'(i);
               fr.px      = pos_now[i][0][MSP_FRAC_EXTRA +: 16];
               fr.py      = pos_now[i][1][MSP_FRAC_EXTRA +: 16];
               fr.pz      = pos_now[i][2][MSP_FRAC_EXTRA +: 16];
               fr.gain    = gain_now[i][MSP_FRAC_EXTRA +: 18];
               fr.audible = audible_now[i];
               fr.last    = (i + 1 == n_src);
               pending_frames.push_back(fr);
            end
         end
         default: ;  // unused op: ignored
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking: every response transaction against the oldest frame.
   // ---------------------------------------------------------------------
   task automatic match_field(input string name, input int src, input longint want,
                              input longint got);
      if (want != got) begin
         $display("%0t: source %0d %s mismatch, expected %0d, actual %0d",
                  $time, src, name, want, got);
         errors++;
      end
   endtask

   task automatic check_frame();
      source_frame_t want;
      if (pending_frames.size() == 0) begin
         $display("%0t: unexpected result transaction, source %0d", $time, rsp_bus.out_source);
         errors++;
      end else begin
         want = pending_frames.pop_front();
         match_field("out_source", want.src, want.src, rsp_bus.out_source);
         match_field("position_x", want.src, $signed(want.px), rsp_bus.position_x);
         match_field("position_y", want.src, $signed(want.py), rsp_bus.position_y);
         match_field("position_z", want.src, $signed(want.pz), rsp_bus.position_z);
         match_field("gain_level", want.src, $signed(want.gain), rsp_bus.gain_level);
         match_field("audible", want.src, want.audible, rsp_bus.audible);
         match_field("last", want.src, want.last, rsp_bus.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) check_frame();
   end

   // Receiver pacing: random stalls, a quiet stretch on request, and one long
   // hold-off counted here so that the block fills up and stalls its input.
   initial begin : rsp_pacing
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transaction on any port ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Every task is entered and left at a rising edge.
   // ---------------------------------------------------------------------
   // Offers one request transaction; valid stays high after acceptance so a
   // following item goes out back to back.
   task automatic send_item(input ramp_cmd_t cmd);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= cmd.op;
      req_bus.source_index <= cmd.src;
      req_bus.target_x     <= cmd.tx;
      req_bus.target_y     <= cmd.ty;
      req_bus.target_z     <= cmd.tz;
      req_bus.target_gain  <= cmd.gain;
      req_bus.ramp_time_us <= cmd.ramp;
      do @(posedge clock); while (!req_bus.ready);
      advance_ramps(cmd);
   endtask

   // Sender pause: all frames back, then room for a silent set to finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write, then a read back of the same register.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] mask;
      mask = (addr == CSR_FRAME_ADDR) ? 32'h000F_FFFF : 32'h0000_000F;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) != (value & mask)) begin
         $display("%0t: register 0x%0h read back mismatch, expected %0d, actual %0d",
                  $time, addr, value & mask, csr_prdata & mask);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (addr == CSR_FRAME_ADDR) frame_us = value[19:0];
      else active_cfg = value[3:0];
   endtask

   task automatic configure(input logic [19:0] frame, input logic [3:0] active);
      settle();
      write_register(CSR_FRAME_ADDR, 32'(frame));
      write_register(CSR_ACTIVE_ADDR, 32'(active));
   endtask

   // ---------------------------------------------------------------------
   // Item builders
   // ---------------------------------------------------------------------
   function automatic ramp_cmd_t set_cmd(int src, int x, int y, int z, int g, int ramp);
      ramp_cmd_t c;
      c.op   = MSP_OP_SET;
      c.src  = 3'(src);
      c.tx   = 16'(x);
      c.ty   = 16'(y);
      c.tz   = 16'(z);
      c.gain = 18'(g);
      c.ramp = 24'(ramp);
      return c;
   endfunction

   // Mute, tick or unused op; the payload it carries is noise.
   function automatic ramp_cmd_t op_cmd(logic [1:0] op);
      ramp_cmd_t c;
      c.op   = op;
      c.src  = 3'($urandom);
      c.tx   = 16'($urandom);
      c.ty   = 16'($urandom);
      c.tz   = 16'($urandom);
      c.gain = 18'($urandom);
      c.ramp = 24'($urandom);
      return c;
   endfunction

   function automatic logic [15:0] pick_pos();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [17:0] pick_gain();
      case ($urandom_range(9))
         0:       return 18'h1FFFF;
         1:       return 18'h20000;
         2:       return 18'(GAIN_FLOOR_DB + $signed($urandom_range(4)) - 2);
         3:       return GAIN_MUTE_DB;
         default: return 18'($urandom);
      endcase
   endfunction

   // Mostly short glides of a few blocks so that they run to the end.
   function automatic logic [23:0] pick_ramp();
      int unsigned ft;
      int unsigned r;
      ft = (frame_us == 0) ? 1 : frame_us;
      r  = $urandom_range(99);
      if (r < 30) return '0;
      if (r < 88) return 24'(ft * $urandom_range(6, 1) - $urandom_range(ft - 1, 0));
      return 24'($urandom);
   endfunction

   function automatic ramp_cmd_t random_cmd();
      ramp_cmd_t   c;
      int          n_src;
      int unsigned r;
      n_src = sources_in_use();
      r     = $urandom_range(99);
      if (r < 40) return op_cmd(MSP_OP_TICK);
      if (r < 93) begin
         c.op   = MSP_OP_SET;
         c.src  = (n_src > 0 && $urandom_range(99) < 85) ? 3'($urandom_range(n_src - 1))
                                                          : 3'($urandom);
         c.tx   = pick_pos();
         c.ty   = pick_pos();
         c.tz   = pick_pos();
         c.gain = pick_gain();
         c.ramp = pick_ramp();
         return c;
      end
      if (r < 98) return op_cmd(MSP_OP_MUTE);
      return op_cmd(OP_UNUSED);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Straight out of reset every source is muted and silent.
   task automatic test_reset_state();
      send_item(op_cmd(MSP_OP_TICK));
   endtask

   // Jumps to the field extremes and to either side of the audibility floor.
   task automatic test_jump_extremes();
      send_item(set_cmd(0, 32767, -32768, 21845, 131071, 0));
      send_item(set_cmd(7, -32768, 32767, -1, -131072, 0));
      send_item(set_cmd(2, 4096, -4096, 1, GAIN_FLOOR_DB, 0));
      send_item(set_cmd(3, 4096, -4096, 1, GAIN_FLOOR_DB - 1, 0));
      send_item(op_cmd(MSP_OP_TICK));
   endtask

   // Full-range glide over three blocks: silent first block zeroes the
   // position, so the last step runs past the top and saturates.
   task automatic test_glide_saturation();
      send_item(set_cmd(4, -32768, -32768, -32768, -131072, 0));
      send_item(set_cmd(4, 32767, 32767, 32767, 131071, 3 * FRAME_DEF));
      repeat (4) send_item(op_cmd(MSP_OP_TICK));
   endtask

   // Mute in the middle of full-range gain glides: stepping on from -200 dB
   // overshoots both ends of the gain range. One ramp is one over a block
   // multiple to exercise the ceiling.
   task automatic test_mute_during_glide();
      send_item(set_cmd(0, 0, 0, 0, -131072, 2 * FRAME_DEF));
      send_item(set_cmd(7, 0, 0, 0, 131071, 2 * FRAME_DEF + 1));
      send_item(op_cmd(MSP_OP_MUTE));
      repeat (3) send_item(op_cmd(MSP_OP_TICK));
   endtask

   // A jump cancels a glide in progress.
   task automatic test_jump_cancels_glide();
      send_item(set_cmd(1, 1000, 2000, 3000, 0, 24'hFF_FFFF));
      send_item(set_cmd(1, -5, 7, 9, 0, 0));
      send_item(op_cmd(MSP_OP_TICK));
   endtask

   // Unused op and a set beyond the active count leave no trace.
   task automatic test_ignored_items();
      configure(MSP_FRAME_RESET, 4'd3);
      send_item(op_cmd(OP_UNUSED));
      send_item(set_cmd(5, 100, 200, 300, 0, 0));
      send_item(op_cmd(MSP_OP_TICK));
   endtask

   // A zero frame time counts as one microsecond per block.
   task automatic test_zero_frame();
      configure(20'd0, 4'd3);
      send_item(set_cmd(2, -20000, 20000, 12345, 0, 5));
      send_item(op_cmd(MSP_OP_TICK));
   endtask

   // Receiver holds off for a long stretch while ticks keep coming, then
   // the sender waits for every frame.
   task automatic test_backpressure();
      configure(MSP_FRAME_RESET, MSP_ACTIVE_RESET);
      long_hold_req = 1'b1;
      repeat (5) send_item(op_cmd(MSP_OP_TICK));
      settle();
   endtask

   // Random phases under several register settings, extremes included;
   // one phase runs with no idling on either side.
   task automatic test_random_phases();
      logic [19:0] phase_frame  [PHASES];
      logic [3:0]  phase_active [PHASES];
      ramp_cmd_t   c;
      int          counted;
      phase_frame  = '{MSP_FRAME_RESET, 20'd0, 20'hF_FFFF, 20'd1, 20'd3000, 20'($urandom)};
      phase_active = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'($urandom_range(8, 1))};
      for (int p = 0; p < PHASES; p++) begin
         configure(phase_frame[p], phase_active[p]);
         steady_flow = (p == 2);
         counted     = 0;
         while (counted < PHASE_ITEMS) begin
            c = random_cmd();
            // transactions the block only drops do not count
            if (c.op != OP_UNUSED &&
                !(c.op == MSP_OP_SET && int'(c.src) >= sources_in_use()))
               counted++;
            send_item(c);
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin : main_seq
      req_bus.valid        = 1'b0;
      req_bus.op           = '0;
      req_bus.source_index = '0;
      req_bus.target_x     = '0;
      req_bus.target_y     = '0;
      req_bus.target_z     = '0;
      req_bus.target_gain  = '0;
      req_bus.ramp_time_us = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      errors               = 0;
      idle_cycles          = 0;
      steady_flow          = 1'b0;
      long_hold_req        = 1'b0;
      reset_ramp_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_jump_extremes();
      test_glide_saturation();
      test_mute_during_glide();
      test_jump_cancels_glide();
      test_ignored_items();
      test_zero_frame();
      test_backpressure();
      test_random_phases();

      settle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/msp_pkg.sv
rtl/core/msp_if.sv
rtl/core/msp_ram.sv
rtl/core/msp_div.sv
rtl/core/msp_sat_add.sv
rtl/core/multi_source_parameter_ramp.sv
test/multi_source_parameter_ramp_tb.sv
